### design/wesema_pkg.sv
// shared types, constants and helper functions for the weighted error score block
// no dependencies: every other design file refers to this package by scoped names
package wesema_pkg;

  // fixed point format
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned SCORE_W = FRAC_BITS + 1;
  localparam int unsigned METRIC_W = 16;
  localparam int unsigned PROD_W = 2 * SCORE_W;
  localparam int unsigned WSUM_W = SCORE_W + 1;
  localparam int unsigned OUT_COUNT_W = 32;
  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned STEP_W = 5;

  localparam logic [SCORE_W-1:0] ONE_Q = SCORE_W'(1 << FRAC_BITS);
  localparam logic [SCORE_W-1:0] HALF_Q = SCORE_W'(1 << (FRAC_BITS - 1));
  localparam logic [SCORE_W-1:0] BLEND_ENT = SCORE_W'((3 * (1 << FRAC_BITS) + 5) / 10);
  localparam logic [SCORE_W-1:0] BLEND_DRF = SCORE_W'((2 * (1 << FRAC_BITS) + 5) / 10);
  localparam logic [SCORE_W-1:0] ALPHA_MIN = SCORE_W'(((1 << FRAC_BITS) + 50) / 100);

  // register reset values
  localparam logic [SCORE_W-1:0] ALPHA_RST = SCORE_W'(3482);
  localparam logic [SCORE_W-1:0] DRIFT_W_RST = SCORE_W'(2048);
  localparam logic [SCORE_W-1:0] ENT_W_RST = SCORE_W'(1024);
  localparam logic [SCORE_W-1:0] RES_W_RST = SCORE_W'(1024);

  // sequencer steps of the back end
  localparam logic [STEP_W-1:0] STEP_NUM_FIRST = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_NUM_MID = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_NUM_LAST = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_WAVE_A = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_WAVE_B = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_DIV_FIRST = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_DIV_LAST = STEP_W'(STEP_DIV_FIRST + SCORE_W - 1);
  localparam logic [STEP_W-1:0] STEP_CONT_A = STEP_W'(STEP_DIV_LAST + 1);
  localparam logic [STEP_W-1:0] STEP_CONT_B = STEP_W'(STEP_DIV_LAST + 2);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTHING = 2'd0,
    REG_DRIFT_W   = 2'd1,
    REG_ENT_W     = 2'd2,
    REG_RES_W     = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_DONE
  } back_state_e;

  // one classified item between front and back
  typedef struct packed {
    logic               clear;
    logic [SCORE_W-1:0] res;
    logic [SCORE_W-1:0] ent;
    logic [SCORE_W-1:0] drf;
    logic [SCORE_W-1:0] wave;
  } item_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [SCORE_W-1:0] alpha;
    logic [SCORE_W-1:0] drift_w;
    logic [SCORE_W-1:0] ent_w;
    logic [SCORE_W-1:0] res_w;
  } cfg_t;

  function automatic logic [SCORE_W-1:0] cap_one(input logic [PROD_W-1:0] v);
    return (v > PROD_W'(ONE_Q)) ? ONE_Q : v[SCORE_W-1:0];
  endfunction

  function automatic logic [METRIC_W-2:0] non_negative(input logic [METRIC_W-1:0] v);
    return v[METRIC_W-1] ? '0 : v[METRIC_W-2:0];
  endfunction

endpackage

### design/wesema_front.sv
// front end: accepts items, clamps the metrics and forms the fixed-blend wave score
// depends on wesema_pkg
module wesema_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic signed [wesema_pkg::METRIC_W-1:0] residual_level_i,
  input  logic signed [wesema_pkg::METRIC_W-1:0] entropy_collapse_i,
  input  logic signed [wesema_pkg::METRIC_W-1:0] norm_drift_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output wesema_pkg::item_t                   push_item_o
);

  localparam int unsigned PW = wesema_pkg::PROD_W;
  localparam int unsigned FB = wesema_pkg::FRAC_BITS;

  logic [wesema_pkg::METRIC_W-2:0] nn_res;
  logic [wesema_pkg::METRIC_W-2:0] nn_ent;
  logic [wesema_pkg::METRIC_W-2:0] nn_drf;
  logic [wesema_pkg::SCORE_W-1:0]  res;
  logic [wesema_pkg::SCORE_W-1:0]  ent;
  logic [wesema_pkg::SCORE_W-1:0]  drf;
  logic [PW-1:0]                   wave_sum;
  wesema_pkg::item_t               item_d;
  wesema_pkg::item_t               item_q;
  logic                            valid_q;

  // clamp the metrics into 0..one, residual halved first
  always_comb begin
    nn_res = wesema_pkg::non_negative(residual_level_i);
    nn_ent = wesema_pkg::non_negative(entropy_collapse_i);
    nn_drf = wesema_pkg::non_negative(norm_drift_i);
    res = wesema_pkg::cap_one(PW'(nn_res >> 1));
    ent = wesema_pkg::cap_one(PW'(nn_ent));
    drf = wesema_pkg::cap_one(PW'(nn_drf));
  end

  // fixed blend 0.5 / 0.3 / 0.2 rounded to nearest
  always_comb begin
    wave_sum = (PW'(res) << (FB - 1))
             + PW'(ent) * PW'(wesema_pkg::BLEND_ENT)
             + PW'(drf) * PW'(wesema_pkg::BLEND_DRF)
             + PW'(wesema_pkg::HALF_Q);
    item_d.clear = kind_i;
    item_d.res   = res;
    item_d.ent   = ent;
    item_d.drf   = drf;
    item_d.wave  = wesema_pkg::cap_one(wave_sum >> FB);
  end

  assign in_ready_o   = !valid_q || push_ready_i;
  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (push_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

### design/wesema_queue.sv
// short item queue between front and back ends
// depends on wesema_pkg
module wesema_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  wesema_pkg::item_t push_item_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output wesema_pkg::item_t pop_item_o
);

  localparam int unsigned DEPTH = wesema_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  wesema_pkg::item_t mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push;
  logic              do_pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### design/wesema_back.sv
// back end: weighted mean through a shared multiplier and serial divider, then averages
// depends on wesema_pkg
module wesema_back #(
  parameter int unsigned COUNT_BITS = wesema_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pop_valid_i,
  output logic                           pop_ready_o,
  input  wesema_pkg::item_t              pop_item_i,
  input  wesema_pkg::cfg_t               cfg_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [COUNT_BITS-1:0]          count_o,
  output logic [wesema_pkg::SCORE_W-1:0] current_wave_o,
  output logic [wesema_pkg::SCORE_W-1:0] average_wave_o,
  output logic [wesema_pkg::SCORE_W-1:0] current_cont_o,
  output logic [wesema_pkg::SCORE_W-1:0] average_cont_o
);

  localparam int unsigned SW = wesema_pkg::SCORE_W;
  localparam int unsigned PW = wesema_pkg::PROD_W;
  localparam int unsigned WW = wesema_pkg::WSUM_W;
  localparam int unsigned FB = wesema_pkg::FRAC_BITS;
  localparam int unsigned TW = wesema_pkg::STEP_W;

  wesema_pkg::back_state_e state_q, state_d;
  logic [TW-1:0]           step_q;
  wesema_pkg::item_t       job_q;
  logic [PW-1:0]           num_q;
  logic [PW-1:0]           wema_q;
  logic [PW-1:0]           cema_q;
  logic [WW-1:0]           rem_q;
  logic [SW-1:0]           low_q;
  logic [SW-1:0]           quo_q;

  logic [COUNT_BITS-1:0]   count_q;
  logic [SW-1:0]           last_wave_q;
  logic [SW-1:0]           avg_wave_q;
  logic [SW-1:0]           last_cont_q;
  logic [SW-1:0]           avg_cont_q;
  logic                    out_valid_q;

  logic                    take;
  logic                    commit;
  logic [SW-1:0]           mul_a;
  logic [SW-1:0]           mul_b;
  logic [PW-1:0]           prod;
  logic [PW-1:0]           num_final;
  logic [WW-1:0]           wsum;
  logic [WW-1:0]           divisor;
  logic [WW:0]             trial;
  logic [WW:0]             diff;
  logic                    fits;
  logic                    div_on;
  logic [COUNT_BITS-1:0]   count_inc;
  logic                    first;
  logic [SW-1:0]           new_avg_wave;
  logic [SW-1:0]           new_avg_cont;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wesema_pkg::BK_IDLE: begin
        if (pop_valid_i) begin
          state_d = pop_item_i.clear ? wesema_pkg::BK_DONE : wesema_pkg::BK_CALC;
        end
      end
      wesema_pkg::BK_CALC: begin
        if (step_q == wesema_pkg::STEP_CONT_B) begin
          state_d = wesema_pkg::BK_DONE;
        end
      end
      wesema_pkg::BK_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = wesema_pkg::BK_IDLE;
        end
      end
      default: state_d = wesema_pkg::BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop_ready_o = 1'b0;
    commit      = 1'b0;
    unique case (state_q)
      wesema_pkg::BK_IDLE: pop_ready_o = 1'b1;
      wesema_pkg::BK_CALC: ;
      wesema_pkg::BK_DONE: commit = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign take = pop_valid_i && pop_ready_o;

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_q)
      wesema_pkg::STEP_NUM_FIRST: begin
        mul_a = cfg_i.drift_w;
        mul_b = job_q.drf;
      end
      wesema_pkg::STEP_NUM_MID: begin
        mul_a = cfg_i.ent_w;
        mul_b = job_q.ent;
      end
      wesema_pkg::STEP_NUM_LAST: begin
        mul_a = cfg_i.res_w;
        mul_b = job_q.res;
      end
      wesema_pkg::STEP_WAVE_A: begin
        mul_a = cfg_i.alpha;
        mul_b = avg_wave_q;
      end
      wesema_pkg::STEP_WAVE_B: begin
        mul_a = wesema_pkg::ONE_Q - cfg_i.alpha;
        mul_b = job_q.wave;
      end
      wesema_pkg::STEP_CONT_A: begin
        mul_a = cfg_i.alpha;
        mul_b = avg_cont_q;
      end
      wesema_pkg::STEP_CONT_B: begin
        mul_a = wesema_pkg::ONE_Q - cfg_i.alpha;
        mul_b = quo_q;
      end
      default: ;
    endcase
    prod      = PW'(mul_a) * PW'(mul_b);
    num_final = num_q + prod;
  end

  // weight sum, zero sum divides by one
  always_comb begin
    wsum    = WW'(cfg_i.drift_w) + WW'(cfg_i.ent_w) + WW'(cfg_i.res_w);
    divisor = (wsum == '0) ? WW'(wesema_pkg::ONE_Q) : wsum;
    div_on  = (step_q >= wesema_pkg::STEP_DIV_FIRST) && (step_q <= wesema_pkg::STEP_DIV_LAST);
    trial   = {rem_q, low_q[SW-1]};
    diff    = trial - {1'b0, divisor};
    fits    = trial >= {1'b0, divisor};
  end

  // result of the item at commit
  always_comb begin
    count_inc    = count_q + 1'b1;
    first        = count_inc == COUNT_BITS'(1);
    new_avg_wave = first ? job_q.wave : wesema_pkg::cap_one(wema_q >> FB);
    new_avg_cont = first ? quo_q : wesema_pkg::cap_one(cema_q >> FB);
  end

  // state register and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wesema_pkg::BK_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (take) begin
        step_q <= '0;
      end else if (state_q == wesema_pkg::BK_CALC) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // arithmetic working registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q <= pop_item_i;
    end
    if (state_q == wesema_pkg::BK_CALC) begin
      if (step_q == wesema_pkg::STEP_NUM_FIRST) begin
        num_q <= prod;
      end else if (step_q <= wesema_pkg::STEP_NUM_LAST) begin
        num_q <= num_final;
      end
      // quotient fits in a score, so the upper half seeds the remainder
      if (step_q == wesema_pkg::STEP_NUM_LAST) begin
        rem_q <= WW'(num_final[PW-1:SW]);
        low_q <= num_final[SW-1:0];
      end else if (div_on) begin
        rem_q <= fits ? diff[WW-1:0] : trial[WW-1:0];
        low_q <= {low_q[SW-2:0], 1'b0};
        quo_q <= {quo_q[SW-2:0], fits};
      end
      if (step_q == wesema_pkg::STEP_WAVE_A) begin
        wema_q <= prod + PW'(wesema_pkg::HALF_Q);
      end else if (step_q == wesema_pkg::STEP_WAVE_B) begin
        wema_q <= wema_q + prod;
      end
      if (step_q == wesema_pkg::STEP_CONT_A) begin
        cema_q <= prod + PW'(wesema_pkg::HALF_Q);
      end else if (step_q == wesema_pkg::STEP_CONT_B) begin
        cema_q <= cema_q + prod;
      end
    end
  end

  // statistics, which also form the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      last_wave_q <= '0;
      avg_wave_q  <= '0;
      last_cont_q <= '0;
      avg_cont_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (commit) begin
        if (job_q.clear) begin
          count_q     <= '0;
          last_wave_q <= '0;
          avg_wave_q  <= '0;
          last_cont_q <= '0;
          avg_cont_q  <= '0;
        end else begin
          count_q     <= count_inc;
          last_wave_q <= job_q.wave;
          avg_wave_q  <= new_avg_wave;
          last_cont_q <= wesema_pkg::cap_one(PW'(quo_q));
          avg_cont_q  <= new_avg_cont;
        end
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign count_o        = count_q;
  assign current_wave_o = last_wave_q;
  assign average_wave_o = avg_wave_q;
  assign current_cont_o = last_cont_q;
  assign average_cont_o = avg_cont_q;

endmodule

### design/weighted_error_score_ema.sv
// top level of the weighted error score block: configuration registers and wiring
// depends on wesema_pkg, wesema_front, wesema_queue and wesema_back
//
// usage
//   input channel (in_valid_i / in_ready_o) takes one item: kind_i selects observe (0) or
//   clear (1), with three signed q3.12 metrics. output channel (out_valid_o / out_ready_i)
//   returns one result per item: the observation count and the latest and averaged wave
//   and contamination scores in q1.12, as they stand after the item.
//   configuration channel (cfg_valid_i / cfg_ready_o) writes register cfg_index_i with
//   cfg_data_i; always ready. values are clamped on write. write only while the block
//   is idle.
// sequencing
//   an observe item passes through the back end in steps: one pop, three multiply steps
//   on the shared multiplier, thirteen restoring divider steps overlapped with the wave
//   average, two multiply steps for the contamination average, one commit; the back end
//   takes no new item until the commit. a clear item holds the back end only for pop and
//   commit. the front stage and a two-entry queue keep accepting while the back end works
//   or while a result waits.
// reset and stall
//   reset zeroes all statistics and loads the register defaults. when the receiver
//   stalls the result holds, the back end waits before commit and the queue fills up.
module weighted_error_score_ema #(
  parameter int unsigned COUNT_BITS = wesema_pkg::COUNT_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   kind_i,
  input  logic signed [wesema_pkg::METRIC_W-1:0] residual_level_i,
  input  logic signed [wesema_pkg::METRIC_W-1:0] entropy_collapse_i,
  input  logic signed [wesema_pkg::METRIC_W-1:0] norm_drift_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [wesema_pkg::OUT_COUNT_W-1:0]     observed_count_o,
  output logic [wesema_pkg::SCORE_W-1:0]         current_wave_o,
  output logic [wesema_pkg::SCORE_W-1:0]         average_wave_o,
  output logic [wesema_pkg::SCORE_W-1:0]         current_contamination_o,
  output logic [wesema_pkg::SCORE_W-1:0]         average_contamination_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [wesema_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wesema_pkg::SCORE_W-1:0]         cfg_data_i
);

  localparam int unsigned OW = wesema_pkg::OUT_COUNT_W;

  wesema_pkg::cfg_t  cfg_q;
  wesema_pkg::item_t push_item;
  wesema_pkg::item_t pop_item;
  logic              push_valid;
  logic              push_ready;
  logic              pop_valid;
  logic              pop_ready;
  logic [COUNT_BITS-1:0] count;
  logic [wesema_pkg::SCORE_W-1:0] alpha_clamped;
  logic [wesema_pkg::SCORE_W-1:0] weight_clamped;

  assign cfg_ready_o = 1'b1;

  // clamp written values
  always_comb begin
    weight_clamped = (cfg_data_i > wesema_pkg::ONE_Q) ? wesema_pkg::ONE_Q : cfg_data_i;
    alpha_clamped  = (cfg_data_i < wesema_pkg::ALPHA_MIN) ? wesema_pkg::ALPHA_MIN
                                                          : weight_clamped;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha   <= wesema_pkg::ALPHA_RST;
      cfg_q.drift_w <= wesema_pkg::DRIFT_W_RST;
      cfg_q.ent_w   <= wesema_pkg::ENT_W_RST;
      cfg_q.res_w   <= wesema_pkg::RES_W_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (wesema_pkg::cfg_reg_e'(cfg_index_i))
        wesema_pkg::REG_SMOOTHING: cfg_q.alpha   <= alpha_clamped;
        wesema_pkg::REG_DRIFT_W:   cfg_q.drift_w <= weight_clamped;
        wesema_pkg::REG_ENT_W:     cfg_q.ent_w   <= weight_clamped;
        wesema_pkg::REG_RES_W:     cfg_q.res_w   <= weight_clamped;
      endcase
    end
  end

  wesema_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .residual_level_i   (residual_level_i),
    .entropy_collapse_i (entropy_collapse_i),
    .norm_drift_i       (norm_drift_i),
    .push_valid_o       (push_valid),
    .push_ready_i       (push_ready),
    .push_item_o        (push_item)
  );

  wesema_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  wesema_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_item_i     (pop_item),
    .cfg_i          (cfg_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .count_o        (count),
    .current_wave_o (current_wave_o),
    .average_wave_o (average_wave_o),
    .current_cont_o (current_contamination_o),
    .average_cont_o (average_contamination_o)
  );

  // fit the count into the fixed-width result field
  generate
    if (COUNT_BITS >= OW) begin : g_count_trunc
      assign observed_count_o = count[OW-1:0];
    end else begin : g_count_ext
      assign observed_count_o = {{(OW - COUNT_BITS){1'b0}}, count};
    end
  endgenerate

endmodule
